// File: src/pfa_pkg.sv
package pfa_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_ROW_LEN   = 1024;
  localparam int ADDR_BITS     = $clog2(MAX_ROW_LEN);
  localparam int DIM_BITS      = 11;
  localparam int CMP_BITS      = DIM_BITS + 1;
  localparam int WIN_BITS      = 4;

  localparam logic [WIN_BITS-1:0] MAX_WINDOW = 4'd8;
  localparam logic [DIM_BITS-1:0] MAX_DIM    = DIM_BITS'(MAX_ROW_LEN);

  localparam int POS_BITS      = $clog2(MAX_WINDOW);
  localparam int AREA_BITS     = 2 * POS_BITS + 1;
  localparam int ACC_BITS      = SAMPLE_BITS + 2 * POS_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam int DIV_CNT_BITS  = $clog2(ACC_BITS + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POOL_MODE,
    CFG_WINDOW_W,
    CFG_WINDOW_H,
    CFG_IN_WIDTH,
    CFG_IN_HEIGHT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } pfa_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic load_out;
  } pfa_cmd_t;

  typedef struct packed {
    logic produce;
    logic avg_mode;
    logic div_done;
    logic out_free;
  } pfa_status_t;

endpackage

// File: src/pfa_div.sv
module pfa_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pfa_pkg::ACC_BITS-1:0] dividend_i,
  input  logic [pfa_pkg::AREA_BITS-1:0]       divisor_i,
  output logic                                done_o,
  output logic [pfa_pkg::SAMPLE_BITS-1:0]     quotient_o
);
  import pfa_pkg::*;

  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    neg_q;
  logic [ACC_BITS-1:0]     quo_q;
  logic [AREA_BITS-1:0]    rem_q;
  logic [AREA_BITS-1:0]    div_q;
  logic [AREA_BITS:0]      rem_sh;
  logic                    ge;
  logic [AREA_BITS:0]      rem_sub;
  logic [ACC_BITS-1:0]     mag;
  logic [ACC_BITS-1:0]     signed_quo;

  assign mag     = dividend_i[ACC_BITS-1] ? ACC_BITS'(-dividend_i) : ACC_BITS'(dividend_i);
  assign rem_sh  = {rem_q, quo_q[ACC_BITS-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_BITS'(ACC_BITS);
      neg_q <= dividend_i[ACC_BITS-1];
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - DIV_CNT_BITS'(1);
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[ACC_BITS-2:0], ge};
      rem_q <= ge ? rem_sub[AREA_BITS-1:0] : rem_sh[AREA_BITS-1:0];
    end
  end

  assign done_o     = cnt_q == DIV_CNT_BITS'(1);
  assign signed_quo = neg_q ? (~quo_q + ACC_BITS'(1)) : quo_q;
  assign quotient_o = signed_quo[SAMPLE_BITS-1:0];

endmodule

// File: src/pfa_datapath.sv
module pfa_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [pfa_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic signed [pfa_pkg::SAMPLE_BITS-1:0] sample_i,
  input  pfa_pkg::pfa_cmd_t                     cmd_i,
  output pfa_pkg::pfa_status_t                  status_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [pfa_pkg::SAMPLE_BITS-1:0] pooled_value_o,
  output logic                                  plane_done_o
);
  import pfa_pkg::*;

  function automatic logic [WIN_BITS-1:0] clamp_win(input logic [WIN_BITS-1:0] v);
    logic [WIN_BITS-1:0] r;
    r = v;
    if (v == '0) r = WIN_BITS'(1);
    else if (v > MAX_WINDOW) r = MAX_WINDOW;
    return r;
  endfunction

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (v == '0) r = DIM_BITS'(1);
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  function automatic logic signed [ACC_BITS-1:0] combine(
    input logic                       max_mode,
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] r;
    if (max_mode) r = (v > acc) ? v : acc;
    else r = acc + v;
    return r;
  endfunction

  // configuration
  logic                pool_mode_q;
  logic [WIN_BITS-1:0] window_w_q;
  logic [WIN_BITS-1:0] window_h_q;
  logic [DIM_BITS-1:0] in_width_q;
  logic [DIM_BITS-1:0] in_height_q;
  logic                restart;

  // position and partials
  logic [ADDR_BITS-1:0]       col_q;
  logic [ADDR_BITS-1:0]       row_q;
  logic [POS_BITS-1:0]        ciw_q;
  logic [POS_BITS-1:0]        riw_q;
  logic [ADDR_BITS-1:0]       ocol_q;
  logic signed [ACC_BITS-1:0] run_q;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [ACC_BITS-1:0]    rd_q;
  logic signed [ACC_BITS-1:0]    row_mem [MAX_ROW_LEN];
  logic signed [ACC_BITS-1:0]    total_q;
  logic                          last_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_val_q;
  logic                          out_last_q;

  logic [WIN_BITS-1:0]        ww_c;
  logic [WIN_BITS-1:0]        wh_c;
  logic [DIM_BITS-1:0]        iw_c;
  logic [DIM_BITS-1:0]        ih_c;
  logic [2*WIN_BITS-1:0]      area_full;
  logic [CMP_BITS-1:0]        col_end;
  logic [CMP_BITS-1:0]        row_end;
  logic                       col_fit;
  logic                       row_fit;
  logic                       in_region;
  logic                       win_end;
  logic                       row_win_end;
  logic                       col_last;
  logic                       row_last;
  logic                       plane_last;
  logic                       produce;
  logic                       mem_we;
  logic signed [ACC_BITS-1:0] s_ext;
  logic signed [ACC_BITS-1:0] run_next;
  logic signed [ACC_BITS-1:0] total;
  logic                       div_done;
  logic [SAMPLE_BITS-1:0]     div_quot;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POOL_MODE, CFG_WINDOW_W, CFG_WINDOW_H, CFG_IN_WIDTH, CFG_IN_HEIGHT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_mode_q <= 1'b1;
      window_w_q  <= WIN_BITS'(2);
      window_h_q  <= WIN_BITS'(2);
      in_width_q  <= MAX_DIM;
      in_height_q <= MAX_DIM;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POOL_MODE: pool_mode_q <= cfg_data_i[0];
        CFG_WINDOW_W:  window_w_q  <= cfg_data_i[WIN_BITS-1:0];
        CFG_WINDOW_H:  window_h_q  <= cfg_data_i[WIN_BITS-1:0];
        CFG_IN_WIDTH:  in_width_q  <= cfg_data_i[DIM_BITS-1:0];
        CFG_IN_HEIGHT: in_height_q <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ww_c      = clamp_win(window_w_q);
  assign wh_c      = clamp_win(window_h_q);
  assign iw_c      = clamp_dim(in_width_q);
  assign ih_c      = clamp_dim(in_height_q);
  assign area_full = ww_c * wh_c;

  // a sample counts when the window it sits in fits inside the plane
  assign col_end   = CMP_BITS'(col_q) - CMP_BITS'(ciw_q) + CMP_BITS'(ww_c);
  assign row_end   = CMP_BITS'(row_q) - CMP_BITS'(riw_q) + CMP_BITS'(wh_c);
  assign col_fit   = col_end <= CMP_BITS'(iw_c);
  assign row_fit   = row_end <= CMP_BITS'(ih_c);
  assign in_region = col_fit && row_fit;

  assign win_end     = (WIN_BITS'(ciw_q) + WIN_BITS'(1)) >= ww_c;
  assign row_win_end = (WIN_BITS'(riw_q) + WIN_BITS'(1)) >= wh_c;
  assign col_last    = (CMP_BITS'(col_q) + CMP_BITS'(1)) >= CMP_BITS'(iw_c);
  assign row_last    = (CMP_BITS'(row_q) + CMP_BITS'(1)) >= CMP_BITS'(ih_c);
  assign plane_last  = ((CMP_BITS'(col_q) + CMP_BITS'(1) + CMP_BITS'(ww_c)) > CMP_BITS'(iw_c))
                    && ((CMP_BITS'(row_q) + CMP_BITS'(1) + CMP_BITS'(wh_c)) > CMP_BITS'(ih_c));

  assign s_ext    = ACC_BITS'(sample_q);
  assign run_next = (ciw_q == '0) ? s_ext : combine(pool_mode_q, run_q, s_ext);
  assign total    = (riw_q == '0) ? run_next : combine(pool_mode_q, rd_q, run_next);
  assign mem_we   = cmd_i.update && in_region && win_end;
  assign produce  = in_region && win_end && row_win_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
  end

  // row store of partial window results
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[ocol_q] <= total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= row_mem[ocol_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ciw_q  <= '0;
      riw_q  <= '0;
      ocol_q <= '0;
      run_q  <= '0;
    end else if (restart) begin
      col_q  <= '0;
      row_q  <= '0;
      ciw_q  <= '0;
      riw_q  <= '0;
      ocol_q <= '0;
      run_q  <= '0;
    end else if (cmd_i.update) begin
      if (in_region) begin
        run_q <= run_next;
      end
      if (col_last) begin
        col_q  <= '0;
        ciw_q  <= '0;
        ocol_q <= '0;
        if (row_last) begin
          row_q <= '0;
          riw_q <= '0;
        end else begin
          if (row_fit) begin
            riw_q <= row_win_end ? '0 : riw_q + POS_BITS'(1);
          end
          row_q <= row_q + ADDR_BITS'(1);
        end
      end else begin
        col_q <= col_q + ADDR_BITS'(1);
        if (in_region) begin
          if (win_end) begin
            ciw_q  <= '0;
            ocol_q <= ocol_q + ADDR_BITS'(1);
          end else begin
            ciw_q <= ciw_q + POS_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && produce) begin
      total_q <= total;
      last_q  <= plane_last;
    end
  end

  pfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total),
    .divisor_i  (AREA_BITS'(area_full)),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_val_q  <= pool_mode_q ? total_q[SAMPLE_BITS-1:0] : div_quot;
      out_last_q <= last_q;
    end
  end

  assign status_o.produce  = produce;
  assign status_o.avg_mode = !pool_mode_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = out_val_q;
  assign plane_done_o   = out_last_q;

endmodule

// File: src/pfa_ctrl.sv
module pfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  pfa_pkg::pfa_status_t status_i,
  output logic                 in_stall_o,
  output pfa_pkg::pfa_cmd_t    cmd_o
);
  import pfa_pkg::*;

  pfa_state_e state_q;
  pfa_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.produce) state_d = status_i.avg_mode ? ST_DIVIDE : ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = 1'b1;
    cmd_o.accept    = 1'b0;
    cmd_o.update    = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.update    = 1'b1;
        cmd_o.div_start = status_i.produce && status_i.avg_mode;
      end
      ST_DIVIDE: ;
      ST_EMIT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: src/pooling_forward_avg_max.sv
// channel   direction  handshake                  payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o    sample_i
// out       out        out_valid_o / out_stall_i  pooled_value_o, plane_done_o
//
// a sample reads the row store when it is accepted, then is combined and written back in the update state
// a max result goes straight to the emit state, an average result first passes the bit-serial 22-step divider
// reset restores the register defaults and the plane position; the row store is not cleared
// a finished result waits in the output register while the next sample is taken
// a new result waits until the output register is free
module pooling_forward_avg_max (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [pfa_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pfa_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pfa_pkg::SAMPLE_BITS-1:0] pooled_value_o,
  output logic                                   plane_done_o
);
  import pfa_pkg::*;

  pfa_cmd_t    cmd;
  pfa_status_t status;

  assign cfg_ready_o = 1'b1;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pfa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pooled_value_o (pooled_value_o),
    .plane_done_o   (plane_done_o)
  );

endmodule

// File: src/pfa_checker.sv
module pfa_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [pfa_pkg::SAMPLE_BITS-1:0] pooled_value_o,
  input logic                                   plane_done_o
);

  // a transfer on the input keeps the input stalled in the next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a new result only shows up while an item is in work
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(pooled_value_o) && $stable(plane_done_o)))
    else $error("output payload changed while stalled");

endmodule

bind pooling_forward_avg_max pfa_checker u_pfa_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import pfa_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
  } pooled_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i = CFG_POOL_MODE;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] pooled_value_o;
  logic                          plane_done_o;

  logic signed [SAMPLE_BITS-1:0] sample_q [$];
  pooled_t                       expected_pooled_q [$];
  int                            n_errors = 0;
  int                            pooled_seen = 0;
  int                            samples_queued = 0;
  int                            idle_cycles = 0;
  logic                          quiet = 1'b0;
  logic                          hold_go = 1'b0;
  logic                          hold_done = 1'b0;
  int                            hold_left = 0;

  // pooling state as seen from outside
  logic [CFG_DATA_BITS-1:0] mode_reg, win_w_reg, win_h_reg, width_reg, height_reg;
  int partial_row [MAX_ROW_LEN];
  int run_acc, col, row, col_in_win, row_in_win, out_col;

  pooling_forward_avg_max i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pooled_value_o (pooled_value_o),
    .plane_done_o   (plane_done_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int eff_dim(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int fold_window(int acc, int v);
    if (mode_reg[0]) return (v > acc) ? v : acc;
    return acc + v;
  endfunction

  function automatic void restart_plane();
    run_acc = 0;
    col = 0;
    row = 0;
    col_in_win = 0;
    row_in_win = 0;
    out_col = 0;
  endfunction

  function automatic void note_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      CFG_POOL_MODE: mode_reg = d & 11'h001;
      CFG_WINDOW_W:  win_w_reg = d & 11'h00F;
      CFG_WINDOW_H:  win_h_reg = d & 11'h00F;
      CFG_IN_WIDTH:  width_reg = d;
      CFG_IN_HEIGHT: height_reg = d;
      default:       return;
    endcase
    restart_plane();
  endfunction

  function automatic void pool_sample(logic signed [SAMPLE_BITS-1:0] s);
    int ww, wh, iw, ih, ow, oh, total, v, sv;
    pooled_t r;
    ww = eff_dim(int'(win_w_reg), int'(MAX_WINDOW));
    wh = eff_dim(int'(win_h_reg), int'(MAX_WINDOW));
    iw = eff_dim(int'(width_reg), int'(MAX_DIM));
    ih = eff_dim(int'(height_reg), int'(MAX_DIM));
    ow = iw / ww;
    oh = ih / wh;
    sv = int'(s);
    if (col < ow * ww && row < oh * wh) begin
      run_acc = (col_in_win == 0) ? sv : fold_window(run_acc, sv);
      if (col_in_win + 1 >= ww) begin
        total = (row_in_win == 0) ? run_acc : fold_window(partial_row[out_col], run_acc);
        partial_row[out_col] = total;
        if (row_in_win + 1 >= wh) begin
          v = mode_reg[0] ? total : total / (ww * wh);
          r.value = v[SAMPLE_BITS-1:0];
          r.last = (out_col + 1 == ow && row + 1 == oh * wh);
          expected_pooled_q.push_back(r);
        end
        col_in_win = 0;
        out_col++;
      end else begin
        col_in_win++;
      end
    end
    if (col + 1 >= iw) begin
      col = 0;
      col_in_win = 0;
      out_col = 0;
      if (row + 1 >= ih) begin
        row = 0;
        row_in_win = 0;
      end else begin
        if (row < oh * wh) row_in_win = (row_in_win + 1 >= wh) ? 0 : row_in_win + 1;
        row++;
      end
    end else begin
      col++;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] junk_bits(logic [CFG_DATA_BITS-1:0] mask);
    if ($urandom_range(0, 3) == 0) return CFG_DATA_BITS'($urandom) & mask;
    return '0;
  endfunction

  task automatic push_samples(int n);
    for (int k = 0; k < n; k++) begin
      sample_q.push_back(pick_sample());
      samples_queued++;
    end
  endtask

  task automatic push_value(logic signed [SAMPLE_BITS-1:0] s, int n);
    for (int k = 0; k < n; k++) begin
      sample_q.push_back(s);
      samples_queued++;
    end
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || expected_pooled_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(logic [CFG_DATA_BITS-1:0] mode, logic [CFG_DATA_BITS-1:0] ww,
                             logic [CFG_DATA_BITS-1:0] wh, logic [CFG_DATA_BITS-1:0] iw,
                             logic [CFG_DATA_BITS-1:0] ih);
    cfg_reg_e                 order [5];
    logic [CFG_DATA_BITS-1:0] vals [5];
    order = '{CFG_POOL_MODE, CFG_WINDOW_W, CFG_WINDOW_H, CFG_IN_WIDTH, CFG_IN_HEIGHT};
    vals = '{mode, ww, wh, iw, ih};
    for (int k = 0; k < 5; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      note_cfg(order[k], vals[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) pool_sample(sample_i);
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transfer
      end else if (sample_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
        in_valid_i <= 1'b1;
        sample_i <= sample_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 36);
    end
  end

  // result check
  always @(posedge clk_i) begin : result_check
    pooled_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pooled_seen++;
      if (expected_pooled_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected transfer, expected none, got value %0d last %0b",
                 $time, pooled_value_o, plane_done_o);
      end else begin
        want = expected_pooled_q.pop_front();
        if (pooled_value_o !== want.value) begin
          n_errors++;
          $display("%0t: pooled_value mismatch, expected %0d, got %0d",
                   $time, want.value, pooled_value_o);
        end
        if (plane_done_o !== want.last) begin
          n_errors++;
          $display("%0t: plane_done mismatch, expected %0b, got %0b",
                   $time, want.last, plane_done_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int mode, ww, wh, iw, ih, n, plane, pick, phase;
    mode_reg = 11'd1;
    win_w_reg = 11'd2;
    win_h_reg = 11'd2;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    restart_plane();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, partial window then restart
    push_samples(2);
    wait_drain();
    // average of extremes on a 2x2 plane, one plane of each extreme
    load_config(11'd0, 11'd2, 11'd2, 11'd2, 11'd2);
    push_value(16'sh8000, 4);
    push_value(16'sh7FFF, 4);
    wait_drain();
    // zero window and zero dimensions act as one
    load_config(11'd1, 11'd0, 11'd0, 11'd0, 11'd0);
    push_value(16'sh8000, 1);
    push_value(16'sh7FFF, 1);
    push_value(16'sh0000, 1);
    wait_drain();
    // oversized window and width clamp, average rounds toward zero
    load_config(11'd0, 11'd15, 11'd1, 11'd2047, 11'd1);
    push_value(-16'sd1, 7);
    push_value(16'sh0000, 1);
    push_value(16'sd5, 1);
    wait_drain();
    // window wider than the plane gives nothing
    load_config(11'd1, 11'd4, 11'd1, 11'd3, 11'd1);
    push_samples(3);
    wait_drain();

    phase = 0;
    while (samples_queued < 1700 || pooled_seen < 60) begin
      if (phase == 0) begin
        // one full-width row
        iw = $urandom_range(1017, 2047);
        load_config(CFG_DATA_BITS'($urandom_range(0, 1)), CFG_DATA_BITS'($urandom_range(1, 8)),
                    11'd1, CFG_DATA_BITS'(iw), CFG_DATA_BITS'($urandom_range(1, 2)));
        push_samples(eff_dim(iw, int'(MAX_DIM)) + $urandom_range(0, 30));
      end else if (phase == 2) begin
        // output held off while the input keeps offering samples
        load_config(11'd1, 11'd1, 11'd1, 11'd16, 11'd16);
        quiet <= 1'b1;
        hold_go <= 1'b1;
        push_samples(256);
      end else if (phase > 2 && $urandom_range(0, 3) == 0) begin
        // carry on in the same plane, maybe after a write to an unused index
        if ($urandom_range(0, 1) == 1) begin
          cfg_valid_i <= 1'b1;
          cfg_index_i <= CFG_IDX_BITS'(int'(CFG_IN_HEIGHT) + $urandom_range(1, 3));
          cfg_data_i <= CFG_DATA_BITS'($urandom);
          @(posedge clk_i);
          while (!cfg_ready_o) @(posedge clk_i);
          note_cfg(cfg_index_i, cfg_data_i);
          cfg_valid_i <= 1'b0;
        end
        push_samples($urandom_range(10, 60));
      end else begin
        mode = $urandom_range(0, 1);
        pick = $urandom_range(0, 9);
        ww = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        pick = $urandom_range(0, 9);
        wh = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        pick = $urandom_range(0, 14);
        iw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1025, 2047) : $urandom_range(1, 24);
        pick = $urandom_range(0, 14);
        ih = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1000, 2047) : $urandom_range(1, 12);
        load_config(CFG_DATA_BITS'(mode) | junk_bits(11'h7FE),
                    CFG_DATA_BITS'(ww) | junk_bits(11'h7F0),
                    CFG_DATA_BITS'(wh) | junk_bits(11'h7F0),
                    CFG_DATA_BITS'(iw), CFG_DATA_BITS'(ih));
        plane = eff_dim(iw, int'(MAX_DIM)) * eff_dim(ih, int'(MAX_DIM));
        if (plane <= 150) n = plane * $urandom_range(1, 2) + $urandom_range(0, plane / 2);
        else n = $urandom_range(40, 150);
        push_samples(n);
      end
      wait_drain();
      quiet <= 1'b0;
      phase++;
    end

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: pooling_forward_avg_max.f
src/pfa_pkg.sv
src/pfa_div.sv
src/pfa_datapath.sv
src/pfa_ctrl.sv
src/pooling_forward_avg_max.sv
src/pfa_checker.sv
tb/tb.sv
